// ===== rtl/core/vcm_pkg.sv =====
// ----------------------------------------------------------------------------
// vcm_pkg
// Shared types, codes and widths for the velocity command mux.
// ----------------------------------------------------------------------------
package vcm_pkg;

    // Saturation width of the scaled joystick command
    localparam int VALUE_BITS = 16;
    // Held command width: wide enough for a raw 16-bit navigation command
    localparam int HELD_W     = (VALUE_BITS > 16) ? VALUE_BITS : 16;
    // Product path width, gain (17 bit signed) times axis (16 bit signed)
    localparam int PROD_W     = 33;

    localparam int GAIN_W     = 16;
    localparam int STEP_W     = 14;
    localparam int LIMIT_W    = 15;
    localparam int CMD_W      = 16;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int IDLE_W     = 8;

    localparam logic [GAIN_W-1:0] LINEAR_GAIN_RST  = 16'd4915;
    localparam logic [GAIN_W-1:0] ANGULAR_GAIN_RST = 16'd4289;

    typedef enum logic [1:0] {
        FUNC_JOY  = 2'd0,
        FUNC_NAV  = 2'd1,
        FUNC_TICK = 2'd2,
        FUNC_RSVD = 2'd3
    } vcm_func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINEAR_STEP   = 3'd0,
        CFG_LINEAR_LIMIT  = 3'd1,
        CFG_ANGULAR_STEP  = 3'd2,
        CFG_ANGULAR_LIMIT = 3'd3,
        CFG_STALE_TICKS   = 3'd4
    } vcm_cfg_idx_t;

    localparam logic KIND_CMD     = 1'b0;
    localparam logic KIND_PROCEED = 1'b1;

    typedef struct packed {
        vcm_func_t          func;
        logic               manual_hold;
        logic               btn_up;
        logic               btn_down;
        logic               btn_left;
        logic               btn_right;
        logic               btn_touchpad;
        logic               joy_connected;
        logic signed [15:0] axis_lx;
        logic signed [15:0] axis_ly;
        logic signed [15:0] nav_linear;
        logic signed [15:0] nav_angular;
    } vcm_item_t;

    typedef struct packed {
        logic                    out_kind;
        logic signed [CMD_W-1:0] linear_cmd;
        logic signed [CMD_W-1:0] angular_cmd;
        logic                    manual_mode;
    } vcm_result_t;

endpackage

// ===== rtl/core/vcm_in_reg.sv =====
// ----------------------------------------------------------------------------
// vcm_in_reg
// Input register stage: holds one request until the core consumes it.
// ----------------------------------------------------------------------------
module vcm_in_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  vcm_pkg::vcm_item_t  s_item,
    input  logic                advance,
    output logic                item_valid,
    output vcm_pkg::vcm_item_t  item
);
    import vcm_pkg::*;

    logic      valid_reg;
    vcm_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== rtl/core/vcm_gain_step.sv =====
// ----------------------------------------------------------------------------
// vcm_gain_step
// Steps one gain up then down on button edges, clamped to [step, limit].
// ----------------------------------------------------------------------------
module vcm_gain_step (
    input  logic [vcm_pkg::GAIN_W-1:0]  gain,
    input  logic                        inc,
    input  logic                        dec,
    input  logic [vcm_pkg::STEP_W-1:0]  step,
    input  logic [vcm_pkg::LIMIT_W-1:0] limit,
    output logic [vcm_pkg::GAIN_W-1:0]  gain_next
);
    import vcm_pkg::*;

    localparam int SUM_W = GAIN_W + 2;

    logic signed [SUM_W-1:0] step_s;
    logic signed [SUM_W-1:0] limit_s;
    logic signed [SUM_W-1:0] g0;
    logic signed [SUM_W-1:0] up_sum;
    logic signed [SUM_W-1:0] up_clamp;
    logic signed [SUM_W-1:0] g1;
    logic signed [SUM_W-1:0] dn_sum;
    logic signed [SUM_W-1:0] dn_clamp;
    logic signed [SUM_W-1:0] g2;

    assign step_s  = $signed(SUM_W'(step));
    assign limit_s = $signed(SUM_W'(limit));
    assign g0      = $signed(SUM_W'(gain));

    // limit applied last, so it wins over step
    function automatic logic signed [SUM_W-1:0] clamp(
        input logic signed [SUM_W-1:0] g,
        input logic signed [SUM_W-1:0] lo,
        input logic signed [SUM_W-1:0] hi
    );
        logic signed [SUM_W-1:0] t;
        t = (g < lo) ? lo : g;
        return (t > hi) ? hi : t;
    endfunction

    assign up_sum   = g0 + step_s;
    assign up_clamp = clamp(up_sum, step_s, limit_s);
    assign g1       = inc ? up_clamp : g0;
    assign dn_sum   = g1 - step_s;
    assign dn_clamp = clamp(dn_sum, step_s, limit_s);
    assign g2       = dec ? dn_clamp : g1;

    assign gain_next = g2[GAIN_W-1:0];

endmodule

// ===== rtl/core/vcm_scale.sv =====
// ----------------------------------------------------------------------------
// vcm_scale
// Scales a Q1.15 stick axis by a Q4.12 gain, rounds to Q4.12 and saturates.
// ----------------------------------------------------------------------------
module vcm_scale (
    input  logic [vcm_pkg::GAIN_W-1:0]        gain,
    input  logic signed [15:0]                axis,
    output logic signed [vcm_pkg::HELD_W-1:0] cmd
);
    import vcm_pkg::*;

    localparam logic signed [PROD_W-1:0] SAT_HI =
        (PROD_W'(1) <<< (VALUE_BITS - 1)) - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);
    localparam logic signed [PROD_W-1:0] ROUND  = PROD_W'(16384);

    logic signed [PROD_W-1:0] gain_s;
    logic signed [PROD_W-1:0] axis_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] q;
    logic signed [PROD_W-1:0] sat;

    assign gain_s = $signed(PROD_W'(gain));
    assign axis_s = PROD_W'(axis);
    assign prod   = gain_s * axis_s;
    // Q5.27 to Q4.12, round half up, floor shift
    assign q      = (prod + ROUND) >>> 15;
    assign sat    = (q > SAT_HI) ? SAT_HI : ((q < SAT_LO) ? SAT_LO : q);
    assign cmd    = sat[HELD_W-1:0];

endmodule

// ===== rtl/core/vcm_out_reg.sv =====
// ----------------------------------------------------------------------------
// vcm_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module vcm_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  vcm_pkg::vcm_result_t result,
    output logic                 out_free,
    output logic                 m_valid,
    input  logic                 m_ready,
    output vcm_pkg::vcm_result_t m_result
);
    import vcm_pkg::*;

    logic        valid_reg;
    vcm_result_t result_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

// ===== rtl/core/teleop_velocity_command_mux_unit.sv =====
// ----------------------------------------------------------------------------
// teleop_velocity_command_mux_unit
// Joystick / navigation velocity command mux with gain stepping and publish.
// ----------------------------------------------------------------------------
// One request is accepted per cycle, sustained, except while the result
// register holds a result that m_ready has not taken: any request, with or
// without a result, then waits in the input register, so input stalls follow
// output stalls cycle for cycle. A request lands in the input register; the
// mode, gain and held-command state plus the result register update from it
// once the result register is free. The path between them is the gain step
// adders feeding one 17x16 multiplier per axis. Joystick reports give a
// result only on a touchpad rising edge, nav commands never, publish ticks
// always. Configuration must be written through cfg_we/cfg_index/cfg_wdata
// while no request is in flight; the block itself does not enforce this.
module teleop_velocity_command_mux_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_we,
    input  logic [vcm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vcm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_func,
    input  logic                                s_manual_hold,
    input  logic                                s_btn_up,
    input  logic                                s_btn_down,
    input  logic                                s_btn_left,
    input  logic                                s_btn_right,
    input  logic                                s_btn_touchpad,
    input  logic                                s_joy_connected,
    input  logic signed [15:0]                  s_axis_lx,
    input  logic signed [15:0]                  s_axis_ly,
    input  logic signed [15:0]                  s_nav_linear,
    input  logic signed [15:0]                  s_nav_angular,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_out_kind,
    output logic signed [15:0]                  m_linear_cmd,
    output logic signed [15:0]                  m_angular_cmd,
    output logic                                m_manual_mode
);
    import vcm_pkg::*;

    // configuration registers
    logic [12:0]          linear_step_reg;
    logic [LIMIT_W-1:0]   linear_limit_reg;
    logic [13:0]          angular_step_reg;
    logic [LIMIT_W-1:0]   angular_limit_reg;
    logic [IDLE_W-1:0]    stale_ticks_reg;

    // block state
    logic                     manual_reg,       manual_next;
    logic                     link_reg,         link_next;
    logic [4:0]               prev_btn_reg,     prev_btn_next;
    logic [GAIN_W-1:0]        lin_gain_reg,     lin_gain_next;
    logic [GAIN_W-1:0]        ang_gain_reg,     ang_gain_next;
    logic signed [HELD_W-1:0] held_lin_reg,     held_lin_next;
    logic signed [HELD_W-1:0] held_ang_reg,     held_ang_next;
    logic [IDLE_W-1:0]        idle_reg,         idle_next;

    vcm_item_t   s_item;
    vcm_item_t   item;
    logic        item_valid;
    logic        advance;
    logic        out_free;
    logic        res_valid;
    vcm_result_t res;
    vcm_result_t m_result;

    logic [4:0]               btn_now;
    logic [4:0]               btn_rise;
    logic [GAIN_W-1:0]        lin_gain_step;
    logic [GAIN_W-1:0]        ang_gain_step;
    logic signed [HELD_W-1:0] lin_scaled;
    logic signed [HELD_W-1:0] ang_scaled;
    logic                     tick_manual;
    logic [IDLE_W-1:0]        tick_idle;
    logic                     tick_stale;

    assign s_item = '{
        func:          vcm_func_t'(s_func),
        manual_hold:   s_manual_hold,
        btn_up:        s_btn_up,
        btn_down:      s_btn_down,
        btn_left:      s_btn_left,
        btn_right:     s_btn_right,
        btn_touchpad:  s_btn_touchpad,
        joy_connected: s_joy_connected,
        axis_lx:       s_axis_lx,
        axis_ly:       s_axis_ly,
        nav_linear:    s_nav_linear,
        nav_angular:   s_nav_angular
    };

    vcm_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    assign advance = item_valid && out_free;

    // bit0 up, bit1 down, bit2 left, bit3 right, bit4 touchpad
    assign btn_now  = {item.btn_touchpad, item.btn_right, item.btn_left,
                       item.btn_down, item.btn_up};
    assign btn_rise = btn_now & ~prev_btn_reg;

    vcm_gain_step u_lin_gain (
        .gain      (lin_gain_reg),
        .inc       (btn_rise[0]),
        .dec       (btn_rise[1]),
        .step      (STEP_W'(linear_step_reg)),
        .limit     (linear_limit_reg),
        .gain_next (lin_gain_step)
    );

    vcm_gain_step u_ang_gain (
        .gain      (ang_gain_reg),
        .inc       (btn_rise[2]),
        .dec       (btn_rise[3]),
        .step      (angular_step_reg),
        .limit     (angular_limit_reg),
        .gain_next (ang_gain_step)
    );

    vcm_scale u_lin_scale (
        .gain (lin_gain_step),
        .axis (item.axis_lx),
        .cmd  (lin_scaled)
    );

    vcm_scale u_ang_scale (
        .gain (ang_gain_step),
        .axis (item.axis_ly),
        .cmd  (ang_scaled)
    );

    // tick: drop to autonomous on lost link, count idle, zero a stale command
    assign tick_manual = manual_reg && link_reg;
    assign tick_idle   = (idle_reg == {IDLE_W{1'b1}}) ? idle_reg : idle_reg + IDLE_W'(1);
    assign tick_stale  = !tick_manual && (tick_idle >= stale_ticks_reg);

    always_comb begin
        manual_next   = manual_reg;
        link_next     = link_reg;
        prev_btn_next = prev_btn_reg;
        lin_gain_next = lin_gain_reg;
        ang_gain_next = ang_gain_reg;
        held_lin_next = held_lin_reg;
        held_ang_next = held_ang_reg;
        idle_next     = idle_reg;
        res_valid     = 1'b0;
        res           = '{out_kind: KIND_CMD, linear_cmd: '0, angular_cmd: '0,
                          manual_mode: manual_reg};
        unique case (item.func)
            FUNC_JOY: begin
                prev_btn_next = btn_now;
                link_next     = item.joy_connected;
                manual_next   = item.manual_hold;
                lin_gain_next = lin_gain_step;
                ang_gain_next = ang_gain_step;
                if (item.manual_hold) begin
                    held_lin_next = lin_scaled;
                    held_ang_next = ang_scaled;
                end
                res_valid       = btn_rise[4];
                res.out_kind    = KIND_PROCEED;
                res.manual_mode = item.manual_hold;
            end
            FUNC_NAV: begin
                idle_next = '0;
                if (!manual_reg) begin
                    held_lin_next = HELD_W'(item.nav_linear);
                    held_ang_next = HELD_W'(item.nav_angular);
                end
            end
            FUNC_TICK: begin
                manual_next = tick_manual;
                idle_next   = tick_idle;
                if (tick_stale) begin
                    held_lin_next = '0;
                    held_ang_next = '0;
                end
                res_valid       = 1'b1;
                res.out_kind    = KIND_CMD;
                res.linear_cmd  = held_lin_next[CMD_W-1:0];
                res.angular_cmd = held_ang_next[CMD_W-1:0];
                res.manual_mode = tick_manual;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            manual_reg   <= 1'b0;
            link_reg     <= 1'b0;
            prev_btn_reg <= '0;
            lin_gain_reg <= LINEAR_GAIN_RST;
            ang_gain_reg <= ANGULAR_GAIN_RST;
            held_lin_reg <= '0;
            held_ang_reg <= '0;
            idle_reg     <= '0;
        end else if (advance) begin
            manual_reg   <= manual_next;
            link_reg     <= link_next;
            prev_btn_reg <= prev_btn_next;
            lin_gain_reg <= lin_gain_next;
            ang_gain_reg <= ang_gain_next;
            held_lin_reg <= held_lin_next;
            held_ang_reg <= held_ang_next;
            idle_reg     <= idle_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            linear_step_reg   <= 13'd410;
            linear_limit_reg  <= 15'd6144;
            angular_step_reg  <= 14'd1430;
            angular_limit_reg <= 15'd25736;
            stale_ticks_reg   <= 8'd60;
        end else if (cfg_we) begin
            unique case (vcm_cfg_idx_t'(cfg_index))
                CFG_LINEAR_STEP:   linear_step_reg   <= cfg_wdata[12:0];
                CFG_LINEAR_LIMIT:  linear_limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                CFG_ANGULAR_STEP:  angular_step_reg  <= cfg_wdata[13:0];
                CFG_ANGULAR_LIMIT: angular_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                CFG_STALE_TICKS:   stale_ticks_reg   <= cfg_wdata[IDLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    vcm_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && res_valid),
        .result   (res),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_out_kind    = m_result.out_kind;
    assign m_linear_cmd  = m_result.linear_cmd;
    assign m_angular_cmd = m_result.angular_cmd;
    assign m_manual_mode = m_result.manual_mode;

endmodule
